### design/assert_macros.svh
// assert_macros.svh: assertion macros shared by the dhzt design files.
// Macros use the local clk_i and rst_ni; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DHZT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");
`define DHZT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: assertion failed");
`else
`define DHZT_ASSERT(lbl, prop)
`define DHZT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### design/dhzt_pkg.sv
// dhzt_pkg: sizes, codes, command/status structs and the modulo fold step
// for the zoned double-hashing table. No dependencies.
package dhzt_pkg;

  localparam int unsigned TableSize = 1021;
  localparam int unsigned Zones     = 4;
  localparam int unsigned AllSlots  = TableSize * Zones;

  localparam int unsigned KeyW      = 31;
  localparam int unsigned ZoneW     = 2;
  localparam int unsigned SlotW     = $clog2(TableSize);
  localparam int unsigned AddrW     = $clog2(AllSlots);
  localparam int unsigned OutcomeW  = 2;

  // 2^FoldShift is congruent to a small constant modulo T and T-1
  localparam int unsigned FoldShift = SlotW;
  localparam int unsigned FoldSteps = 4;
  localparam int unsigned FoldCntW  = $clog2(FoldSteps);
  localparam logic [KeyW-1:0] FoldMulA = KeyW'((1 << FoldShift) - TableSize);
  localparam logic [KeyW-1:0] FoldMulB = KeyW'((1 << FoldShift) - (TableSize - 1));
  localparam logic [KeyW-1:0] FoldMask = KeyW'((1 << FoldShift) - 1);

  localparam logic OpInsert = 1'b0;
  localparam logic OpProbe  = 1'b1;

  localparam logic [OutcomeW-1:0] OutInserted = 2'd0;
  localparam logic [OutcomeW-1:0] OutFound    = 2'd1;
  localparam logic [OutcomeW-1:0] OutNotFound = 2'd2;
  localparam logic [OutcomeW-1:0] OutFull     = 2'd3;

  typedef struct packed {
    logic                clr_wr;    // clearing pass write
    logic                load;      // capture accepted item
    logic                fold;      // one modulo fold step
    logic                fix;       // final correction, set first slot and stride
    logic                rd;        // read table word at current slot
    logic                advance;   // step to next slot in probe sequence
    logic                ins_wr;    // store key at current slot
    logic                out_load;  // load output register
    logic [OutcomeW-1:0] outcome;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic occ;
    logic match;
    logic last_probe;
    logic is_probe;
  } dp_status_t;

  // x mod m step with 2^FoldShift == c (mod m): result keeps the residue
  function automatic logic [KeyW-1:0] fold_step(input logic [KeyW-1:0] x,
                                                input logic [KeyW-1:0] c);
    logic [KeyW-1:0] hi;
    logic [KeyW-1:0] lo;
    hi = x >> FoldShift;
    lo = x & FoldMask;
    return KeyW'(hi * c) + lo;
  endfunction

endpackage

### design/double_hash_zoned_table.sv
// double_hash_zoned_table: zoned open-addressing hash table with double hashing.
// Items are handled one at a time: a new item is taken only after the result
//   of the last one has gone to the output register. Each item probes 1 .. 1021
//   slots, each read through the single table read port. A finished result may
//   wait in the output register while the next item is taken.
// Reset: asynchronous, active low; a pass then clears all 4084 table words.
module double_hash_zoned_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [dhzt_pkg::ZoneW-1:0]         zone_i,
  input  logic [dhzt_pkg::KeyW-1:0]          key_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dhzt_pkg::OutcomeW-1:0]      outcome_o,
  output logic [dhzt_pkg::SlotW-1:0]         slot_o
);
  import dhzt_pkg::*;

  // Flow per item:
  //   accept -> FoldSteps fold steps reduce key mod T and mod T-1 (2^10 folds to 3 / 4)
  //   -> fix: first slot and stride -> per slot: read word, check it
  //   -> result to output register once it is free.
  // Table words are {occupied, key}; the clearing pass zeroes every word,
  // so key bits of a never-written word are never compared as valid.

  dp_cmd_t    cmd;
  dp_status_t status;

  dhzt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dhzt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .operation_i (operation_i),
    .zone_i      (zone_i),
    .key_i       (key_i),
    .outcome_o   (outcome_o),
    .slot_o      (slot_o)
  );

endmodule

### design/dhzt_datapath.sv
// dhzt_datapath: hash arithmetic, probe position, table memory and output
// register. Depends on dhzt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dhzt_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dhzt_pkg::dp_cmd_t                cmd_i,
  output dhzt_pkg::dp_status_t             status_o,
  input  logic                             operation_i,
  input  logic [dhzt_pkg::ZoneW-1:0]       zone_i,
  input  logic [dhzt_pkg::KeyW-1:0]        key_i,
  output logic [dhzt_pkg::OutcomeW-1:0]    outcome_o,
  output logic [dhzt_pkg::SlotW-1:0]       slot_o
);
  import dhzt_pkg::*;

  logic                op_q;
  logic [KeyW-1:0]     key_q;
  logic [AddrW-1:0]    base_q;
  logic [KeyW-1:0]     fa_q, fb_q;
  logic [SlotW-1:0]    pos_q, stride_q, probe_cnt_q;
  logic [AddrW-1:0]    clr_addr_q;
  logic [KeyW:0]       rdata_q;
  logic [KeyW:0]       mem_q [AllSlots];
  logic [OutcomeW-1:0] outcome_q;
  logic [SlotW-1:0]    slot_q;

  logic [AddrW-1:0]    addr, waddr;
  logic [KeyW:0]       wdata;
  logic                we;
  logic [SlotW-1:0]    fa_low, fb_low, pos_fix, fb_red, stride_fix, pos_next;
  logic [SlotW:0]      step_sum;

  assign addr   = base_q + AddrW'(pos_q);
  assign fa_low = fa_q[SlotW-1:0];
  assign fb_low = fb_q[SlotW-1:0];

  // after FoldSteps folds both residues are below 2^SlotW, under twice the modulus
  assign pos_fix    = (fa_low >= SlotW'(TableSize)) ? fa_low - SlotW'(TableSize) : fa_low;
  assign fb_red     = (fb_low >= SlotW'(TableSize - 1)) ?
                      fb_low - SlotW'(TableSize - 1) : fb_low;
  assign stride_fix = fb_red + SlotW'(1);

  assign step_sum = {1'b0, pos_q} + {1'b0, stride_q};
  assign pos_next = (step_sum >= (SlotW + 1)'(TableSize)) ?
                    SlotW'(step_sum - (SlotW + 1)'(TableSize)) : step_sum[SlotW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      key_q  <= key_i;
      // zone field width matches Zones, so the zone needs no reduction
      base_q <= AddrW'(zone_i) * AddrW'(TableSize);
      fa_q   <= key_i;
      fb_q   <= key_i;
    end else if (cmd_i.fold) begin
      fa_q <= fold_step(fa_q, FoldMulA);
      fb_q <= fold_step(fb_q, FoldMulB);
    end
    if (cmd_i.fix) begin
      pos_q       <= pos_fix;
      stride_q    <= stride_fix;
      probe_cnt_q <= '0;
    end else if (cmd_i.advance) begin
      pos_q       <= pos_next;
      probe_cnt_q <= probe_cnt_q + SlotW'(1);
    end
    if (cmd_i.out_load) begin
      outcome_q <= cmd_i.outcome;
      slot_q    <= pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
    end
  end

  // table word: {occupied, key}
  assign we    = cmd_i.clr_wr | cmd_i.ins_wr;
  assign waddr = cmd_i.clr_wr ? clr_addr_q : addr;
  assign wdata = cmd_i.clr_wr ? '0 : {1'b1, key_q};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  assign status_o.clr_last   = (clr_addr_q == AddrW'(AllSlots - 1));
  assign status_o.occ        = rdata_q[KeyW];
  assign status_o.match      = (rdata_q[KeyW-1:0] == key_q);
  assign status_o.last_probe = (probe_cnt_q == SlotW'(TableSize - 1));
  assign status_o.is_probe   = (op_q == OpProbe);

  assign outcome_o = outcome_q;
  assign slot_o    = slot_q;

  `DHZT_ASSERT_NEXT(a_first_slot_range, cmd_i.fix, pos_q < SlotW'(TableSize))
  `DHZT_ASSERT_NEXT(a_stride_range, cmd_i.fix,
                    (stride_q != '0) && (stride_q < SlotW'(TableSize)))
  `DHZT_ASSERT_NEXT(a_next_slot_range, cmd_i.advance, pos_q < SlotW'(TableSize))

endmodule

### design/dhzt_ctrl.sv
// dhzt_ctrl: sequencer for clearing pass, hashing, probe loop and result
// handoff. Depends on dhzt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dhzt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  dhzt_pkg::dp_status_t  status_i,
  output dhzt_pkg::dp_cmd_t     cmd_o
);
  import dhzt_pkg::*;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StFold  = 3'd2;
  localparam logic [2:0] StFix   = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StCheck = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [FoldCntW-1:0] fold_cnt_q, fold_cnt_d;
  logic [OutcomeW-1:0] res_q, res_d;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    fold_cnt_d = fold_cnt_q;
    res_d      = res_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          fold_cnt_d = '0;
          state_d    = StFold;
        end
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        fold_cnt_d = fold_cnt_q + FoldCntW'(1);
        if (fold_cnt_q == FoldCntW'(FoldSteps - 1)) begin
          state_d = StFix;
        end
      end
      StFix: begin
        cmd_o.fix = 1'b1;
        state_d   = StRead;
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d  = StCheck;
      end
      StCheck: begin
        if (!status_i.occ) begin
          // empty slot ends both operations
          if (status_i.is_probe) begin
            res_d = OutNotFound;
          end else begin
            res_d        = OutInserted;
            cmd_o.ins_wr = 1'b1;
          end
          state_d = StDone;
        end else if (status_i.is_probe && status_i.match) begin
          res_d   = OutFound;
          state_d = StDone;
        end else if (status_i.last_probe) begin
          res_d   = status_i.is_probe ? OutNotFound : OutFull;
          state_d = StDone;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = StRead;
        end
      end
      StDone: begin
        cmd_o.outcome = res_q;
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      fold_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fold_cnt_q  <= fold_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  `DHZT_ASSERT(a_insert_only_empty, !cmd_o.ins_wr || (!status_i.occ && !status_i.is_probe))
  `DHZT_ASSERT(a_out_load_free, !cmd_o.out_load || !out_valid_q || out_ready_i)
  `DHZT_ASSERT(a_no_step_past_end, !cmd_o.advance || !status_i.last_probe)
  `DHZT_ASSERT_NEXT(a_out_after_load, cmd_o.out_load, out_valid_q)

endmodule

### bench/double_hash_zoned_table_test.sv
// double_hash_zoned_table_test: self-checking bench for the zoned double-hashing table.
// Predicts every result from its own copy of the zone stores and compares them in order.
// Depends on dhzt_pkg and double_hash_zoned_table only.
module double_hash_zoned_table_test;
  import dhzt_pkg::*;

  // Timing bounds. The slowest single item probes a whole zone, and the clearing
  // pass after reset is longer still.
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RandomItems = 840;
  localparam int unsigned SettleWait  = 2 * (8 + 2 * TableSize);

  typedef struct packed {
    logic [OutcomeW-1:0] outcome;
    logic [SlotW-1:0]    slot;
  } result_t;

  typedef struct packed {
    logic [ZoneW-1:0] zone;
    logic [KeyW-1:0]  key;
  } placed_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                operation_i = OpInsert;
  logic [ZoneW-1:0]    zone_i      = '0;
  logic [KeyW-1:0]     key_i       = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [OutcomeW-1:0] outcome_o;
  logic [SlotW-1:0]    slot_o;

  // Shadow of the block's state: key per slot and the occupancy map.
  logic [KeyW-1:0] key_store  [AllSlots];
  bit              slot_taken [AllSlots];

  result_t pending_results [$];   // predicted, not yet delivered
  placed_t placed_keys [$];       // keys inserted in zones 0..2, for hits

  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned outcome_count [4];
  int unsigned quiet_cycles  = 0;

  // Idle pattern state: each side switches between idling and streaming
  // every few dozen items so both dense and sparse traffic occur.
  int unsigned tx_stretch = 0;
  bit          tx_idles   = 1'b0;
  int unsigned rx_stretch = 0;
  bit          rx_idles   = 1'b0;
  int unsigned rx_wait    = 0;
  int unsigned hold_tag   = 0;
  int unsigned hold_seen  = 0;

  always #1 clk_i = ~clk_i;

  double_hash_zoned_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .zone_i      (zone_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .outcome_o   (outcome_o),
    .slot_o      (slot_o)
  );

  // Walk the double-hash sequence of the key in its zone. An insert takes the
  // first free slot; a probe stops at a free slot or at a matching key. If the
  // walk runs through all slots, the last slot visited is reported.
  function automatic result_t place_or_find(input logic op, input logic [ZoneW-1:0] zn,
                                            input logic [KeyW-1:0] k);
    result_t     r;
    int unsigned first;
    int unsigned stride;
    int unsigned base;
    int unsigned pos;
    int unsigned idx;
    int unsigned i;
    first     = k % TableSize;
    stride    = 1 + k % (TableSize - 1);
    base      = (int'(zn) % Zones) * TableSize;
    pos       = first;
    r.outcome = (op == OpInsert) ? OutFull : OutNotFound;
    for (i = 0; i < TableSize; i++) begin
      pos = (first + i * stride) % TableSize;
      idx = base + pos;
      if (op == OpInsert) begin
        if (!slot_taken[idx]) begin
          key_store[idx]  = k;
          slot_taken[idx] = 1'b1;
          r.outcome       = OutInserted;
          break;
        end
      end else begin
        if (!slot_taken[idx]) begin
          r.outcome = OutNotFound;
          break;
        end
        if (key_store[idx] == k) begin
          r.outcome = OutFound;
          break;
        end
      end
    end
    r.slot = SlotW'(pos);
    return r;
  endfunction

  // Offer one item and hold it until accepted; the prediction is made at the
  // accepting edge so the shadow state follows the block's order exactly.
  // Valid is left high on return, so back-to-back items never drop it.
  task automatic send_item(input logic op, input logic [ZoneW-1:0] zn,
                           input logic [KeyW-1:0] k);
    int unsigned gap;
    if (tx_stretch == 0) begin
      tx_idles   = bit'($urandom_range(0, 1));
      tx_stretch = $urandom_range(10, 60);
    end
    tx_stretch--;
    gap = tx_idles ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      // junk payload while valid is low; the block must ignore it
      in_valid_i  <= 1'b0;
      operation_i <= 1'($urandom);
      zone_i      <= ZoneW'($urandom);
      key_i       <= KeyW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    zone_i      <= zn;
    key_i       <= k;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(place_or_find(op, zn, k));
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Keys spread over the whole range, clustered near slot collisions,
  // in the same first slot as other keys, or near the top of the range.
  function automatic logic [KeyW-1:0] draw_key();
    case ($urandom_range(0, 3))
      0:       return KeyW'($urandom);
      1:       return KeyW'($urandom_range(0, 4 * TableSize));
      2:       return KeyW'($urandom_range(0, TableSize - 1)
                            + TableSize * $urandom_range(1, 2000000));
      default: return KeyW'(31'h7FFF_FFFF - $urandom_range(0, 7));
    endcase
  endfunction

  // Key extremes, slot extremes, collisions on the first slot, chains that
  // end on a free slot, duplicate keys and a probe of an empty zone.
  task automatic test_corner_keys();
    send_item(OpInsert, 2'd0, 31'd0);
    send_item(OpInsert, 2'd0, 31'h7FFF_FFFF);
    send_item(OpInsert, 2'd0, 31'd1020);      // last slot of the zone
    send_item(OpInsert, 2'd0, 31'd2041);      // last slot again, collides
    send_item(OpInsert, 2'd0, 31'd2039);      // widest stride
    send_item(OpProbe,  2'd0, 31'd0);
    send_item(OpProbe,  2'd0, 31'h7FFF_FFFF);
    send_item(OpProbe,  2'd0, 31'd2041);
    send_item(OpProbe,  2'd0, 31'd1);
    send_item(OpInsert, 2'd1, 31'd5);
    send_item(OpInsert, 2'd1, 31'd1026);      // same first slot as 5
    send_item(OpInsert, 2'd1, 31'd2047);
    send_item(OpProbe,  2'd1, 31'd1026);
    send_item(OpProbe,  2'd1, 31'd3068);      // walks the chain, then misses
    send_item(OpProbe,  2'd1, 31'h2AAA_AAAA);
    send_item(OpInsert, 2'd2, 31'd77);
    send_item(OpInsert, 2'd2, 31'd77);        // duplicate stored again
    send_item(OpProbe,  2'd2, 31'd77);
    send_item(OpInsert, 2'd2, 31'h5555_5555);
    send_item(OpProbe,  2'd2, 31'h5555_5555);
    send_item(OpProbe,  2'd3, 31'd1019);      // untouched zone
    wait_all_results();
  endtask

  // Keys 0..T-1 each land in their own first slot, filling zone 3. After that
  // inserts report a full zone and misses run through every slot.
  task automatic test_zone_full();
    int unsigned k;
    for (k = 0; k < TableSize; k++) send_item(OpInsert, 2'd3, KeyW'(k));
    send_item(OpInsert, 2'd3, 31'd5000);
    send_item(OpInsert, 2'd3, 31'd17);
    send_item(OpProbe,  2'd3, 31'd4000);
    send_item(OpProbe,  2'd3, 31'h7FFF_FFFF);
    send_item(OpProbe,  2'd3, 31'd1020);
    send_item(OpProbe,  2'd3, 31'd0);
    wait_all_results();
  endtask

  // The result side stops taking results for a long stretch while items keep
  // coming, so the block fills its output and stalls the input side.
  task automatic test_backpressure();
    int unsigned n;
    logic [KeyW-1:0] k;
    hold_tag <= hold_tag + 1;
    for (n = 0; n < 10; n++) begin
      k = draw_key();
      send_item(OpInsert, 2'd0, k);
      placed_keys.push_back('{zone: 2'd0, key: k});
    end
    wait_all_results();
  endtask

  // Mostly well-formed traffic: inserts followed by hits on keys already
  // stored, duplicates, and misses; a small share goes to the full zone.
  task automatic test_random_traffic();
    int unsigned     n;
    int unsigned     pick;
    logic [ZoneW-1:0] zn;
    logic [KeyW-1:0]  k;
    placed_t          e;
    for (n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 7) != 0)
          send_item(OpProbe, 2'd3, KeyW'($urandom_range(0, TableSize - 1)));
        else
          send_item(1'($urandom), 2'd3, draw_key());
      end else begin
        zn   = ZoneW'($urandom_range(0, 2));
        pick = $urandom_range(0, 9);
        if (pick < 5 || placed_keys.size() == 0) begin
          k = draw_key();
          send_item(OpInsert, zn, k);
          placed_keys.push_back('{zone: zn, key: k});
        end else if (pick < 8) begin
          e = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
          send_item(OpProbe, e.zone, e.key);
        end else if (pick == 8) begin
          send_item(OpProbe, zn, draw_key());
        end else begin
          e = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
          send_item(OpInsert, e.zone, e.key);
        end
      end
      if (n % 400 == 399) wait_all_results();
    end
    wait_all_results();
  endtask

  // Result side: a fresh wait per result, plus the long hold requested by
  // the back-pressure test (noticed at the next clock edge after the request).
  always @(posedge clk_i) begin : result_sink
    if (rx_stretch == 0) begin
      rx_idles   = bit'($urandom_range(0, 1));
      rx_stretch = $urandom_range(10, 60);
    end
    if (out_valid_o && out_ready_i) begin
      rx_stretch--;
      rx_wait = rx_idles ? $urandom_range(0, 6) : 0;
    end
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      rx_wait   = HoldCycles;
    end
    out_ready_i <= (rx_wait == 0);
    if (rx_wait != 0) rx_wait--;
  end

  // Compare each delivered result with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: outcome %0d slot %0d", outcome_o, slot_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        outcome_count[want.outcome]++;
        if (outcome_o !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, outcome_o);
          mismatches++;
        end
        if (slot_o !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, slot_o);
          mismatches++;
        end
      end
    end
  end

  // Ends the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : run
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_keys();
    test_zone_full();
    test_backpressure();
    test_random_traffic();
    wait_all_results();
    // room for any stray result to show up
    repeat (SettleWait) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      mismatches++;
    end
    $display("Sent %0d items: corner keys, a filled zone, long output stall, random traffic.",
             items_sent);
    $display("Checked %0d inserted, %0d found, %0d not found, %0d zone full; %0d mismatches.",
             outcome_count[OutInserted], outcome_count[OutFound],
             outcome_count[OutNotFound], outcome_count[OutFull], mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/dhzt_pkg.sv
design/dhzt_datapath.sv
design/dhzt_ctrl.sv
design/double_hash_zoned_table.sv
bench/double_hash_zoned_table_test.sv
